>>> sv/register_file_alu_macros.svh
// Assertion macros shared by the register file ALU checker.
// No dependencies.
`ifndef REGISTER_FILE_ALU_MACROS_SVH
`define REGISTER_FILE_ALU_MACROS_SVH
// Assert that a property holds on every rising clock edge outside reset.
`define RFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert a property with no reset qualifier.
`define RFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/rfa_pkg.sv
// Shared types and constants for the register file ALU.
// No dependencies.
`default_nettype none
package rfa_pkg;
  localparam int NumRegsDefault   = 16;
  localparam int DataWidthDefault = 32;
  localparam int ReadWidth        = 32;

  localparam logic [2:0] GRP_ARITH   = 3'd1;
  localparam logic [2:0] GRP_LOGIC   = 3'd2;
  localparam logic [2:0] GRP_SHIFT   = 3'd3;
  localparam logic [2:0] GRP_COMPARE = 3'd4;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_INC = 4'd4;
  localparam logic [3:0] OP_DEC = 4'd5;

  localparam logic [3:0] OP_XOR = 4'd0;
  localparam logic [3:0] OP_AND = 4'd1;
  localparam logic [3:0] OP_OR  = 4'd2;
  localparam logic [3:0] OP_NOT = 4'd3;

  localparam logic [3:0] OP_SHR1 = 4'd0;
  localparam logic [3:0] OP_SHL1 = 4'd1;
  localparam logic [3:0] OP_SHRR = 4'd2;
  localparam logic [3:0] OP_SHLR = 4'd3;

  localparam logic [3:0] OP_GT = 4'd0;
  localparam logic [3:0] OP_LT = 4'd1;
  localparam logic [3:0] OP_GE = 4'd2;
  localparam logic [3:0] OP_LE = 4'd3;
  localparam logic [3:0] OP_EQ = 4'd4;
  localparam logic [3:0] OP_NE = 4'd5;

  // Flag bit positions.
  localparam int F_GT = 0;
  localparam int F_LT = 1;
  localparam int F_EQ = 2;
  localparam int F_NE = 3;
  localparam int F_GE = 4;
  localparam int F_LE = 5;

  // Command class decided by the front end.
  typedef enum logic [2:0] {
    K_NONE = 3'b001,
    K_ONE  = 3'b010,
    K_DIV  = 3'b100
  } kind_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;
endpackage
`default_nettype wire

>>> sv/register_file_alu.sv
// Each request passes from the queue through the back end states idle, read and out; a
// division by a nonzero divisor also waits in the divide state, where the divider gives one
// quotient bit per cycle. The back end works on one request at a time.
// A two-entry queue lets the front take requests while the back works.
// Synchronous reset clears all registers, the compare flags and the held read value.
`default_nettype none
module register_file_alu
  import rfa_pkg::*;
#(
  parameter int NUM_REGS   = NumRegsDefault,
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  reg_index,
  input  wire logic        reg_write_en,
  input  wire logic [31:0] write_value,
  input  wire logic        reg_read_en,
  input  wire logic [3:0]  first_index,
  input  wire logic [3:0]  second_index,
  input  wire logic [7:0]  func,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_value,
  output logic             greater_flag,
  output logic             less_flag,
  output logic             equal_flag,
  output logic             not_equal_flag,
  output logic             greater_equal_flag,
  output logic             less_equal_flag
);
  localparam int IdxW = $clog2(NUM_REGS);

  logic q_valid, q_ready, q_wen, q_ren;
  logic [IdxW-1:0] q_idx, q_d, q_s;
  logic [DATA_WIDTH-1:0] q_wdata;
  logic [2:0] q_grp;
  logic [3:0] q_op;
  kind_t q_kind;

  // Front end and request queue.
  rfa_front #(.IdxW(IdxW), .DataW(DATA_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .reg_index, .reg_write_en, .write_value,
    .reg_read_en, .first_index, .second_index, .func,
    .q_valid, .q_ready, .q_idx, .q_wen, .q_wdata, .q_ren, .q_d, .q_s,
    .q_grp, .q_op, .q_kind
  );

  // Back end with the register file.
  rfa_back #(.NumRegs(NUM_REGS), .IdxW(IdxW), .DataW(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_idx, .q_wen, .q_wdata, .q_ren, .q_d, .q_s,
    .q_grp, .q_op, .q_kind, .out_valid, .out_ready, .read_value,
    .greater_flag, .less_flag, .equal_flag, .not_equal_flag,
    .greater_equal_flag, .less_equal_flag
  );
endmodule
`default_nettype wire

>>> sv/rfa_front.sv
// Front end of the register file ALU: accepts requests, classifies them, queues them.
// Depends on rfa_pkg.
`default_nettype none
module rfa_front
  import rfa_pkg::*;
#(
  parameter int IdxW  = 4,
  parameter int DataW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [3:0]       reg_index,
  input  wire logic             reg_write_en,
  input  wire logic [31:0]      write_value,
  input  wire logic             reg_read_en,
  input  wire logic [3:0]       first_index,
  input  wire logic [3:0]       second_index,
  input  wire logic [7:0]       func,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output logic [IdxW-1:0]       q_idx,
  output logic                  q_wen,
  output logic [DataW-1:0]      q_wdata,
  output logic                  q_ren,
  output logic [IdxW-1:0]       q_d,
  output logic [IdxW-1:0]       q_s,
  output logic [2:0]            q_grp,
  output logic [3:0]            q_op,
  output kind_t                 q_kind
);
  localparam int EntW = 3 * IdxW + DataW + 2 + 7 + 3;
  typedef logic [EntW-1:0] ent_t;

  ent_t   ent [2];
  logic   wp, rp;
  logic [1:0] cnt;
  logic   push, pop;
  logic   run;
  logic [2:0] grp;
  logic [3:0] op;
  kind_t  kind;
  logic [IdxW-1:0] i_idx, i_d, i_s;
  logic [DataW-1:0] wdata;

  // Index modulo file depth and data sign extension or truncation.
  always_comb begin
    i_idx = IdxW'(reg_index);
    i_d   = IdxW'(first_index);
    i_s   = IdxW'(second_index);
    wdata = DataW'($signed(write_value));
  end

  // Classify the command.
  always_comb begin
    grp = func[3:1];
    op  = func[7:4];
    run = 1'b0;
    case (grp)
      GRP_ARITH:   run = (op <= OP_DEC);
      GRP_LOGIC:   run = (op <= OP_NOT);
      GRP_SHIFT:   run = (op <= OP_SHLR);
      GRP_COMPARE: run = (op <= OP_NE);
      default:     run = 1'b0;
    endcase
    if (func[0]) run = 1'b0;
    if (!run) kind = K_NONE;
    else if (grp == GRP_ARITH && op == OP_DIV) kind = K_DIV;
    else kind = K_ONE;
  end

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;

  // Two-entry request queue.
  always_ff @(posedge clk) begin
    if (push) ent[wp] <= {i_idx, reg_write_en, wdata, reg_read_en, i_d, i_s, grp, op, kind};
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign {q_idx, q_wen, q_wdata, q_ren, q_d, q_s, q_grp, q_op, q_kind} = ent[rp];
endmodule
`default_nettype wire

>>> sv/rfa_div.sv
// Iterative signed divider, one quotient bit per cycle.
// Depends on rfa_pkg.
`default_nettype none
module rfa_div
  import rfa_pkg::*;
#(
  parameter int DataW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DataW-1:0] a,
  input  wire logic [DataW-1:0] b,
  output logic                  done,
  output logic [DataW-1:0]      quot
);
  localparam int CntW = $clog2(DataW + 1);
  logic [DataW-1:0] rem, q, dvs;
  logic [CntW-1:0]  cnt;
  logic             busy, neg;
  logic [DataW:0]   trial;

  assign trial = {rem, q[DataW-1]} - {1'b0, dvs};

  // Restoring division on magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= a[DataW-1] ? -a : a;
      dvs <= b[DataW-1] ? -b : b;
      neg <= a[DataW-1] ^ b[DataW-1];
    end else if (busy) begin
      if (!trial[DataW]) begin
        rem <= trial[DataW-1:0];
        q   <= {q[DataW-2:0], 1'b1};
      end else begin
        rem <= {rem[DataW-2:0], q[DataW-1]};
        q   <= {q[DataW-2:0], 1'b0};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DataW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -q : q;
endmodule
`default_nettype wire

>>> sv/rfa_back.sv
// Back end of the register file ALU: register file, execution and result register.
// Depends on rfa_pkg and rfa_div.
`default_nettype none
module rfa_back
  import rfa_pkg::*;
#(
  parameter int NumRegs = 16,
  parameter int IdxW    = 4,
  parameter int DataW   = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire logic [IdxW-1:0]  q_idx,
  input  wire logic             q_wen,
  input  wire logic [DataW-1:0] q_wdata,
  input  wire logic             q_ren,
  input  wire logic [IdxW-1:0]  q_d,
  input  wire logic [IdxW-1:0]  q_s,
  input  wire logic [2:0]       q_grp,
  input  wire logic [3:0]       q_op,
  input  wire kind_t            q_kind,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           read_value,
  output logic                  greater_flag,
  output logic                  less_flag,
  output logic                  equal_flag,
  output logic                  not_equal_flag,
  output logic                  greater_equal_flag,
  output logic                  less_equal_flag
);
  localparam int ShW = $clog2(DataW);

  logic [DataW-1:0] regs [NumRegs];
  logic [DataW-1:0] held;
  logic [5:0]       flags;
  state_t           state;
  logic [DataW-1:0] a, b, av, bv, res, quot;
  logic [DataW-1:0] prod;
  logic [ShW-1:0]   amt;
  logic             wr_res, lt_ab, lt_ba, eq;
  logic [5:0]       flags_next;
  logic             div_start, div_done;
  logic             take;
  logic [IdxW-1:0]  dest;

  // Operands as seen after the direct write.
  assign av = (q_wen && q_idx == q_d) ? q_wdata : regs[q_d];
  assign bv = (q_wen && q_idx == q_s) ? q_wdata : regs[q_s];

  // The data width is a power of two, so the low bits are the amount modulo the width.
  assign amt   = b[ShW-1:0];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign eq    = (a == b);
  assign prod  = DataW'(a * b);

  // Combinational command result and compare flags for all commands but division.
  always_comb begin
    res = a;
    wr_res = 1'b1;
    flags_next = flags;
    case (q_grp)
      GRP_ARITH: begin
        case (q_op)
          OP_ADD:  res = a + b;
          OP_SUB:  res = a - b;
          OP_MUL:  res = prod;
          OP_INC:  res = a + 1'b1;
          OP_DEC:  res = a - 1'b1;
          default: wr_res = 1'b0;
        endcase
      end
      GRP_LOGIC: begin
        case (q_op)
          OP_XOR:  res = a ^ b;
          OP_AND:  res = a & b;
          OP_OR:   res = a | b;
          OP_NOT:  res = ~a;
          default: wr_res = 1'b0;
        endcase
      end
      GRP_SHIFT: begin
        case (q_op)
          OP_SHR1: res = DataW'($signed(a) >>> 1);
          OP_SHL1: res = a << 1;
          OP_SHRR: res = DataW'($signed(a) >>> amt);
          OP_SHLR: res = a << amt;
          default: wr_res = 1'b0;
        endcase
      end
      GRP_COMPARE: begin
        wr_res = 1'b0;
        case (q_op)
          OP_GT:   flags_next[F_GT] = lt_ba;
          OP_LT:   flags_next[F_LT] = lt_ab;
          OP_GE:   flags_next[F_GE] = !lt_ab;
          OP_LE:   flags_next[F_LE] = !lt_ba;
          OP_EQ:   flags_next[F_EQ] = eq;
          OP_NE:   flags_next[F_NE] = !eq;
          default: flags_next = flags;
        endcase
      end
      default: wr_res = 1'b0;
    endcase
  end

  rfa_div #(.DataW(DataW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(a), .b(b),
    .done(div_done), .quot(quot)
  );

  assign div_start = (state == S_READ) && (q_kind == K_DIV) && (b != '0);
  assign take = (state == S_IDLE) && q_valid;
  assign q_ready = ((state == S_READ) && q_kind != K_DIV) ||
                   ((state == S_READ) && b == '0) || ((state == S_DIV) && div_done);
  assign dest = q_d;

  // Sequencer: direct write and read, then the command.
  always_ff @(posedge clk) begin
    if (take) begin
      a <= av;
      b <= bv;
    end
    if (rst) begin
      state <= S_IDLE;
      held <= '0;
      flags <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && (!out_valid || out_ready)) begin
            if (q_wen) regs[q_idx] <= q_wdata;
            if (q_ren) held <= q_wen ? q_wdata : regs[q_idx];
            state <= S_READ;
          end
        end
        S_READ: begin
          if (q_kind == K_ONE) begin
            if (wr_res) regs[dest] <= res;
            flags <= flags_next;
          end
          if (div_start) state <= S_DIV;
          else state <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            regs[dest] <= quot;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign read_value         = 32'($signed(held));
  assign greater_flag       = flags[F_GT];
  assign less_flag          = flags[F_LT];
  assign equal_flag         = flags[F_EQ];
  assign not_equal_flag     = flags[F_NE];
  assign greater_equal_flag = flags[F_GE];
  assign less_equal_flag    = flags[F_LE];
endmodule
`default_nettype wire

>>> sv/rfa_checker.sv
// Port-level checker for the register file ALU, bound to the top level.
// Depends on register_file_alu_macros.svh.
`default_nettype none
`include "register_file_alu_macros.svh"
module rfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_value
);
  // Reset leaves no result pending.
  `RFA_ASSERT_ALWAYS(a_rst_out, clk, $past(rst) |-> !out_valid, "result valid after reset")
  // A waiting result holds its value.
  `RFA_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> $stable(read_value), "result changed")
  // Results never come back to back: a taken result drops out_valid before the next one is shown.
  `RFA_ASSERT(a_gap, clk, rst, out_valid && out_ready |=> !out_valid, "back-to-back results")
  // After reset the queue is ready.
  `RFA_ASSERT_ALWAYS(a_rst_in, clk, $past(rst) |-> in_ready, "not ready after reset")
  // A waiting request stays valid until it is taken.
  `RFA_ASSERT(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid, "request dropped")
endmodule
bind register_file_alu rfa_checker u_rfa_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .read_value
);
`default_nettype wire

>>> dv/register_file_alu_checker.sv
// Checker for the register file ALU: watches both channels, predicts each result, compares.
// Depends on rfa_pkg for group, operation and flag position constants.
`default_nettype none
module register_file_alu_checker
  import rfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [3:0]  reg_index,
  input  wire logic        reg_write_en,
  input  wire logic [31:0] write_value,
  input  wire logic        reg_read_en,
  input  wire logic [3:0]  first_index,
  input  wire logic [3:0]  second_index,
  input  wire logic [7:0]  func,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] read_value,
  input  wire logic        greater_flag,
  input  wire logic        less_flag,
  input  wire logic        equal_flag,
  input  wire logic        not_equal_flag,
  input  wire logic        greater_equal_flag,
  input  wire logic        less_equal_flag,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  flags;
  } alu_result_t;

  logic [31:0] model_regs [16];
  logic [5:0]  model_flags;
  logic [31:0] model_read;
  alu_result_t expected_results [$];

  // Apply one request to the model state and queue the outcome.
  task automatic apply_request(input logic [3:0] idx, input logic we, input logic [31:0] wv,
                               input logic re, input logic [3:0] d, input logic [3:0] s,
                               input logic [7:0] fn);
    logic signed [31:0] a, b;
    logic [2:0] grp;
    logic [3:0] op;
    alu_result_t r;
    if (we) model_regs[idx] = wv;
    if (re) model_read = model_regs[idx];
    a = model_regs[d];
    b = model_regs[s];
    grp = fn[3:1];
    op = fn[7:4];
    if (!fn[0]) begin
      case (grp)
        GRP_ARITH: begin
          case (op)
            OP_ADD: model_regs[d] = a + b;
            OP_SUB: model_regs[d] = a - b;
            OP_MUL: model_regs[d] = a * b;
            OP_DIV: if (b != 0) model_regs[d] = (a == 32'sh80000000 && b == -1) ? a : a / b;
            OP_INC: model_regs[d] = a + 1;
            OP_DEC: model_regs[d] = a - 1;
            default: ;
          endcase
        end
        GRP_LOGIC: begin
          case (op)
            OP_XOR: model_regs[d] = a ^ b;
            OP_AND: model_regs[d] = a & b;
            OP_OR:  model_regs[d] = a | b;
            OP_NOT: model_regs[d] = ~a;
            default: ;
          endcase
        end
        GRP_SHIFT: begin
          case (op)
            OP_SHR1: model_regs[d] = a >>> 1;
            OP_SHL1: model_regs[d] = a << 1;
            OP_SHRR: model_regs[d] = a >>> b[4:0];
            OP_SHLR: model_regs[d] = a << b[4:0];
            default: ;
          endcase
        end
        GRP_COMPARE: begin
          case (op)
            OP_GT: model_flags[F_GT] = a > b;
            OP_LT: model_flags[F_LT] = a < b;
            OP_GE: model_flags[F_GE] = a >= b;
            OP_LE: model_flags[F_LE] = a <= b;
            OP_EQ: model_flags[F_EQ] = a == b;
            OP_NE: model_flags[F_NE] = a != b;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.value = model_read;
    r.flags = model_flags;
    expected_results.push_back(r);
  endtask

  // Track requests and compare results on each edge.
  always @(posedge clk) begin
    alu_result_t want;
    logic [5:0] got_flags;
    if (rst) begin
      foreach (model_regs[i]) model_regs[i] = '0;
      model_flags = '0;
      model_read = '0;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (in_valid && in_ready)
        apply_request(reg_index, reg_write_en, write_value, reg_read_en,
                      first_index, second_index, func);
      if (out_valid && out_ready) begin
        result_count++;
        got_flags = '0;
        got_flags[F_GT] = greater_flag;
        got_flags[F_LT] = less_flag;
        got_flags[F_EQ] = equal_flag;
        got_flags[F_NE] = not_equal_flag;
        got_flags[F_GE] = greater_equal_flag;
        got_flags[F_LE] = less_equal_flag;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%h flags=%b", $time, read_value, got_flags);
        end else begin
          want = expected_results.pop_front();
          if (want.value !== read_value) begin
            fail_count++;
            $display("%0t: read_value expected %h actual %h", $time, want.value, read_value);
          end
          if (want.flags !== got_flags) begin
            fail_count++;
            $display("%0t: flags expected %b actual %b", $time, want.flags, got_flags);
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench top for the register file ALU: drives requests, stalls results, gives the verdict.
// Depends on rfa_pkg, register_file_alu and register_file_alu_checker.
`default_nettype none
module tb
  import rfa_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] reg_index = '0;
  logic reg_write_en = 1'b0;
  logic [31:0] write_value = '0;
  logic reg_read_en = 1'b0;
  logic [3:0] first_index = '0;
  logic [3:0] second_index = '0;
  logic [7:0] func = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] read_value;
  logic greater_flag, less_flag, equal_flag, not_equal_flag;
  logic greater_equal_flag, less_equal_flag;
  int fail_count, pending_count, result_count;
  int out_gap = 0;
  int sent_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  register_file_alu DUT (.*);

  register_file_alu_checker checker_inst (.*);

  // No gap or a short one in most cases, now and then a long one.
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side stalls at random, mostly briefly and now and then for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else begin
      out_ready <= 1'b1;
      out_gap = gap_length();
    end
  end

  // Send one request and wait for it to be taken.
  task automatic send_request(input logic [3:0] idx, input logic we, input logic [31:0] wv,
                              input logic re, input logic [3:0] d, input logic [3:0] s,
                              input logic [7:0] fn);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    reg_index <= idx;
    reg_write_en <= we;
    write_value <= wv;
    reg_read_en <= re;
    first_index <= d;
    second_index <= s;
    func <= fn;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  function automatic logic [7:0] make_func(input logic [2:0] grp, input logic [3:0] op);
    return {op, grp, 1'b0};
  endfunction

  // Random operand with a bias toward the edges.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(($urandom_range(0, 40)));
      4: return 32'(-$urandom_range(1, 40));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_func();
    case ($urandom_range(0, 9))
      0: return 8'($urandom());
      1: return make_func(GRP_ARITH, 4'($urandom_range(0, 5)));
      2: return make_func(GRP_ARITH, OP_DIV);
      3: return make_func(GRP_LOGIC, 4'($urandom_range(0, 3)));
      4, 5: return make_func(GRP_SHIFT, 4'($urandom_range(0, 3)));
      default: return make_func(GRP_COMPARE, 4'($urandom_range(0, 5)));
    endcase
  endfunction

  initial begin
    logic [3:0] d, s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: edge operands, every operation, division special cases.
    send_request(4'd1, 1'b1, 32'h8000_0000, 1'b1, 4'd0, 4'd0, 8'h00);
    send_request(4'd2, 1'b1, 32'hffff_ffff, 1'b1, 4'd0, 4'd0, 8'h01);
    send_request(4'd3, 1'b1, 32'h7fff_ffff, 1'b0, 4'd0, 4'd0, 8'hff);
    send_request(4'd15, 1'b1, 32'h0000_0000, 1'b1, 4'd1, 4'd2,
                 make_func(GRP_ARITH, OP_DIV));
    send_request(4'd1, 1'b0, 32'h0, 1'b1, 4'd1, 4'd15, make_func(GRP_ARITH, OP_DIV));
    send_request(4'd4, 1'b1, 32'd100, 1'b0, 4'd4, 4'd2, make_func(GRP_ARITH, OP_DIV));
    send_request(4'd5, 1'b1, 32'd33, 1'b1, 4'd3, 4'd5, make_func(GRP_SHIFT, OP_SHRR));
    send_request(4'd1, 1'b0, 32'h0, 1'b0, 4'd1, 4'd5, make_func(GRP_SHIFT, OP_SHLR));
    for (int g = 1; g <= 4; g++)
      for (int op = 0; op < 6; op++) begin
        if (g != 1 && g != 4 && op > 3) continue;
        send_request(4'($urandom_range(0, 15)), 1'b1, pick_value(), 1'b1,
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     make_func(3'(g), 4'(op)));
      end
    // Let everything drain before the random part.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // Random requests, mostly valid commands on a busy register file.
    for (int n = 0; n < 1600; n++) begin
      d = 4'($urandom_range(0, 15));
      s = ($urandom_range(0, 3) == 0) ? d : 4'($urandom_range(0, 15));
      send_request(4'($urandom()), 1'($urandom()), pick_value(), 1'($urandom()), d, s,
                   pick_func());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("tb: %0d requests covering all command groups and division corner cases,",
             sent_count);
    $display("tb: %0d results checked against the model.", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
